// ===== hdl/max_pool_2d_argmax_assert.svh =====
// Assertion macros shared by the max pooling checker
`ifndef MAX_POOL_2D_ARGMAX_ASSERT_SVH
`define MAX_POOL_2D_ARGMAX_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define MP2A_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("max_pool_2d_argmax assertion failed");

// next-cycle implication, disabled while in reset
`define MP2A_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("max_pool_2d_argmax assertion failed");

`endif

// ===== hdl/mp2a_pkg.sv =====
// Types and constants for the 2-D max pooling block
`timescale 1ns / 1ps
package mp2a_pkg;

    localparam int MAX_WIDTH   = 512;
    localparam int MAX_HEIGHT  = 512;
    localparam int MAX_WINDOW  = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_RESULTS = 64;
    localparam int MEM_AW      = 13;   // 3 bits of window row slot, 10 bits of window column
    localparam int MEM_DEPTH   = 1 << MEM_AW;

    localparam logic [2:0] CFG_IN_WIDTH    = 3'd0;
    localparam logic [2:0] CFG_IN_HEIGHT   = 3'd1;
    localparam logic [2:0] CFG_WINDOW_SIZE = 3'd2;
    localparam logic [2:0] CFG_STEP        = 3'd3;
    localparam logic [2:0] CFG_PAD_TOTAL   = 3'd4;

    localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef logic signed [11:0] t_pos;

    typedef enum logic [3:0] {
        S_SETUP,
        S_DIVW,
        S_DIVH,
        S_SCAN,
        S_ARM,
        S_IDLE,
        S_RD,
        S_UPD,
        S_ADV,
        S_EMPTY,
        S_DONE
    } t_state;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] max_value;
        logic [8:0]                    src_row;
        logic [8:0]                    src_col;
        logic                          window_empty;
        logic [9:0]                    out_row;
        logic [9:0]                    out_col;
        logic [15:0]                   plane;
    } t_res;

endpackage

// ===== hdl/max_pool_2d_argmax.sv =====
// Streaming 2-D max pooling with argmax, one shared sequencer over line stores
// Setup after reset or a register write: two 10-step divisions, then an offset scan.
// Per sample: the sample is taken while idle, then each window that overlaps it gets one store
// read and one update, then the trackers advance. The last sample of a plane also walks the
// empty windows. Result back-pressure stalls the sequencer once two results wait.
// Reset (synchronous, active low) loads default registers and clears plane count and handshakes.
`timescale 1ns / 1ps
module max_pool_2d_argmax
    import mp2a_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_idx,
    input  logic [9:0]                    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_max_value,
    output logic [8:0]                    o_src_row,
    output logic [8:0]                    o_src_col,
    output logic                          o_window_empty,
    output logic [9:0]                    o_out_row,
    output logic [9:0]                    o_out_col,
    output logic [15:0]                   o_plane,
    output logic                          o_last_of_run
);

    // configuration
    logic [9:0] r_in_width, r_in_height;
    logic [3:0] r_window_size, r_step, r_pad_total;

    t_state r_state, n_state;

    // geometry
    logic [9:0] g_w, g_h;
    logic [3:0] g_size, g_s;
    t_pos       sz, st, of, num_w, num_h, h_last, w_last;

    // divider
    logic [9:0] r_div_quo, n_div_quo;
    logic [3:0] r_div_rem, n_div_rem;
    logic [3:0] r_div_cnt, n_div_cnt;
    logic [4:0] div_rem2;
    logic       div_ge, div_last;
    logic [9:0] div_quo_nx;
    logic [3:0] div_rem_nx;

    logic [9:0] r_ow, n_ow, r_oh, n_oh;
    logic [3:0] r_lo0, n_lo0, r_hi0, n_hi0, r_gj, n_gj;
    t_pos       r_lo0_end, n_lo0_end, r_hinext0, n_hinext0, r_gstart, n_gstart;
    logic       scan_done;

    // trackers
    logic [9:0] r_rlo, n_rlo, r_rhi, n_rhi, r_clo, n_clo, r_chi, n_chi;
    t_pos       r_rlo_end, n_rlo_end, r_rhinext, n_rhinext;
    t_pos       r_clo_end, n_clo_end, r_chinext, n_chinext;
    logic [8:0] r_row, n_row, r_col, n_col;
    logic [15:0] r_plane, n_plane;
    logic signed [SAMPLE_BITS-1:0] r_x, n_x;

    // window walk
    logic [9:0] r_wi, n_wi, r_wj, n_wj;
    t_pos       r_wrs, n_wrs, r_wcs, n_wcs;
    logic [9:0] r_it, n_it, r_jt, n_jt, r_ei, n_ei, r_ej, n_ej;
    logic [6:0] r_nres, n_nres;

    // partial store
    logic [SAMPLE_BITS+17:0] r_mem [MEM_DEPTH];
    logic [SAMPLE_BITS+17:0] r_rd;
    logic [MEM_AW-1:0]       mem_addr;
    logic                    mem_we;
    logic [SAMPLE_BITS+17:0] mem_wdata;

    // result path
    logic r_pend_v, n_pend_v;
    t_res r_pend, n_pend;
    logic r_out_v, n_out_v;
    t_res r_out, n_out;
    logic r_out_last, n_out_last;

    // control
    logic in_acc, cfg_hit, out_free, emit_ok;
    logic win_none, upd_go, j_end, win_last, take;
    logic row_first, col_first, row_last, col_last;
    t_pos row_s, col_s, rs_end, cs_end;
    logic signed [SAMPLE_BITS-1:0] old_v;
    logic last_col, last_row, plane_end;
    logic e_done, row_e, col_e, e_hit, e_go;
    logic [9:0] ej1, ej_nx, ei1;
    logic emit_v, out_load, done_flush;
    t_res emit_res;

    // geometry from registers, clamped
    always_comb begin
        if (r_in_width == 10'd0) begin
            g_w = 10'd1;
        end else if (r_in_width > 10'(MAX_WIDTH)) begin
            g_w = 10'(MAX_WIDTH);
        end else begin
            g_w = r_in_width;
        end
        if (r_in_height == 10'd0) begin
            g_h = 10'd1;
        end else if (r_in_height > 10'(MAX_HEIGHT)) begin
            g_h = 10'(MAX_HEIGHT);
        end else begin
            g_h = r_in_height;
        end
        if (r_window_size == 4'd0) begin
            g_size = 4'd1;
        end else if (r_window_size > 4'(MAX_WINDOW)) begin
            g_size = 4'(MAX_WINDOW);
        end else begin
            g_size = r_window_size;
        end
        g_s    = (r_step == 4'd0) ? 4'd1 : r_step;
        sz     = $signed({8'b0, g_size});
        st     = $signed({8'b0, g_s});
        of     = $signed({9'b0, r_pad_total[3:1]});
        num_w  = $signed({2'b0, g_w}) + $signed({8'b0, r_pad_total}) - sz;
        num_h  = $signed({2'b0, g_h}) + $signed({8'b0, r_pad_total}) - sz;
        w_last = $signed({2'b0, g_w}) - 12'sd1;
        h_last = $signed({2'b0, g_h}) - 12'sd1;
    end

    // shared restoring divider step, one quotient bit per cycle
    always_comb begin
        div_rem2   = {r_div_rem, r_div_quo[9]};
        div_ge     = div_rem2 >= {1'b0, g_s};
        div_rem_nx = div_ge ? 4'(div_rem2 - {1'b0, g_s}) : div_rem2[3:0];
        div_quo_nx = {r_div_quo[8:0], div_ge};
        div_last   = (r_div_cnt == 4'd9);
        scan_done  = (r_gstart + st) > 12'sd0;
    end

    // window tests
    always_comb begin
        row_s     = $signed({3'b0, r_row});
        col_s     = $signed({3'b0, r_col});
        rs_end    = r_wrs + sz - 12'sd1;
        cs_end    = r_wcs + sz - 12'sd1;
        row_first = (r_wrs < 12'sd0) ? (r_row == 9'd0) : (row_s == r_wrs);
        col_first = (r_wcs < 12'sd0) ? (r_col == 9'd0) : (col_s == r_wcs);
        row_last  = row_s == ((rs_end > h_last) ? h_last : rs_end);
        col_last  = col_s == ((cs_end > w_last) ? w_last : cs_end);
        win_last  = row_last && col_last;
        old_v     = r_rd[SAMPLE_BITS+17:18];
        take      = (row_first && col_first) || (r_x > old_v);
        win_none  = (r_wi > r_rhi) || (r_wi >= r_oh) || (r_wj > r_chi) || (r_wj >= r_ow);
        j_end     = (r_wj == r_chi) || (10'(r_wj + 10'd1) == r_ow);
        last_col  = ({1'b0, r_col} == 10'(g_w - 10'd1));
        last_row  = ({1'b0, r_row} == 10'(g_h - 10'd1));
        plane_end = last_col && last_row;
        out_free  = !r_out_v || i_out_ready;
        emit_ok   = !r_pend_v || out_free;
        upd_go    = !win_last || emit_ok;
        e_done    = (r_ei >= r_oh) || (r_ow == 10'd0) || r_nres[6];
        row_e     = (r_ei < {6'b0, r_lo0}) || (r_ei >= r_it);
        col_e     = (r_ej < {6'b0, r_lo0}) || (r_ej >= r_jt);
        e_hit     = row_e || col_e;
        e_go      = !e_hit || emit_ok;
        ej1       = 10'(r_ej + 10'd1);
        ej_nx     = (!row_e && (ej1 >= {6'b0, r_lo0}) && (ej1 < r_jt)) ? r_jt : ej1;
        ei1       = 10'(r_ei + 10'd1);
        // rows with no empty column are skipped as a block
        if ((r_lo0 == 4'd0) && (r_jt >= r_ow) && (ei1 >= {6'b0, r_lo0}) && (ei1 < r_it)) begin
            ei1 = r_it;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_SETUP: n_state = S_DIVW;
            S_DIVW:  if (div_last) n_state = S_DIVH;
            S_DIVH:  if (div_last) n_state = S_SCAN;
            S_SCAN:  if (scan_done) n_state = S_ARM;
            S_ARM:   n_state = S_IDLE;
            S_IDLE:  if (in_acc) n_state = S_RD;
            S_RD:    n_state = win_none ? S_ADV : S_UPD;
            S_UPD:   if (upd_go) n_state = S_RD;
            S_ADV:   n_state = plane_end ? S_EMPTY : S_DONE;
            S_EMPTY: if (e_done) n_state = S_DONE;
            S_DONE:  if (emit_ok) n_state = S_IDLE;
            default: n_state = S_SETUP;
        endcase
        if (cfg_hit) begin
            n_state = S_SETUP;
        end
    end

    // control outputs of the sequencer
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        in_acc     = i_in_valid && o_in_ready;
        cfg_hit    = i_cfg_we && (i_cfg_idx <= CFG_PAD_TOTAL);
        mem_addr   = {r_wi[2:0], r_wj};
        mem_we     = (r_state == S_UPD) && upd_go;
        mem_wdata  = take ? {r_x, r_row, r_col} : r_rd;
        emit_v     = 1'b0;
        emit_res   = '0;
        if ((r_state == S_UPD) && upd_go && win_last) begin
            emit_v                = 1'b1;
            emit_res.max_value    = mem_wdata[SAMPLE_BITS+17:18];
            emit_res.src_row      = mem_wdata[17:9];
            emit_res.src_col      = mem_wdata[8:0];
            emit_res.window_empty = 1'b0;
            emit_res.out_row      = r_wi;
            emit_res.out_col      = r_wj;
            emit_res.plane        = r_plane;
        end else if ((r_state == S_EMPTY) && !e_done && e_hit && emit_ok) begin
            emit_v                = 1'b1;
            emit_res.max_value    = MOST_NEG;
            emit_res.window_empty = 1'b1;
            emit_res.out_row      = r_ei;
            emit_res.out_col      = r_ej;
            emit_res.plane        = r_plane;
        end
        done_flush = (r_state == S_DONE) && r_pend_v && out_free;
        out_load   = (emit_v && r_pend_v) || done_flush;
    end

    // datapath next values
    always_comb begin
        n_div_quo = r_div_quo;  n_div_rem = r_div_rem;  n_div_cnt = r_div_cnt;
        n_ow = r_ow;  n_oh = r_oh;
        n_lo0 = r_lo0;  n_hi0 = r_hi0;  n_gj = r_gj;
        n_lo0_end = r_lo0_end;  n_hinext0 = r_hinext0;  n_gstart = r_gstart;
        n_rlo = r_rlo;  n_rhi = r_rhi;  n_clo = r_clo;  n_chi = r_chi;
        n_rlo_end = r_rlo_end;  n_rhinext = r_rhinext;
        n_clo_end = r_clo_end;  n_chinext = r_chinext;
        n_row = r_row;  n_col = r_col;  n_plane = r_plane;  n_x = r_x;
        n_wi = r_wi;  n_wj = r_wj;  n_wrs = r_wrs;  n_wcs = r_wcs;
        n_it = r_it;  n_jt = r_jt;  n_ei = r_ei;  n_ej = r_ej;
        n_nres = r_nres;
        case (r_state)
            S_SETUP: begin
                n_div_quo = num_w[9:0];
                n_div_rem = 4'd0;
                n_div_cnt = 4'd0;
                n_gstart  = -of;
                n_gj      = 4'd0;
                n_lo0     = 4'd0;
                n_lo0_end = sz - 12'sd1 - of;
                n_hi0     = 4'd0;
                n_hinext0 = st - of;
            end
            S_DIVW: begin
                n_div_quo = div_quo_nx;
                n_div_rem = div_rem_nx;
                n_div_cnt = 4'(r_div_cnt + 4'd1);
                if (div_last) begin
                    n_ow      = num_w[11] ? 10'd0 : 10'(div_quo_nx + 10'd1);
                    n_div_quo = num_h[9:0];
                    n_div_rem = 4'd0;
                    n_div_cnt = 4'd0;
                end
            end
            S_DIVH: begin
                n_div_quo = div_quo_nx;
                n_div_rem = div_rem_nx;
                n_div_cnt = 4'(r_div_cnt + 4'd1);
                if (div_last) begin
                    n_oh = num_h[11] ? 10'd0 : 10'(div_quo_nx + 10'd1);
                end
            end
            S_SCAN: begin
                // first window reaching the image, last window starting at or before it
                if ((r_gstart + sz - 12'sd1) < 12'sd0) begin
                    n_lo0     = 4'(r_gj + 4'd1);
                    n_lo0_end = r_gstart + st + sz - 12'sd1;
                end
                if ((r_gstart + st) <= 12'sd0) begin
                    n_hi0     = 4'(r_gj + 4'd1);
                    n_hinext0 = r_gstart + st + st;
                end
                n_gstart = r_gstart + st;
                n_gj     = 4'(r_gj + 4'd1);
            end
            S_ARM: begin
                n_row = 9'd0;  n_col = 9'd0;
                n_rlo = {6'b0, r_lo0};  n_rlo_end = r_lo0_end;
                n_rhi = {6'b0, r_hi0};  n_rhinext = r_hinext0;
                n_clo = {6'b0, r_lo0};  n_clo_end = r_lo0_end;
                n_chi = {6'b0, r_hi0};  n_chinext = r_hinext0;
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_x    = i_sample;
                    n_nres = 7'd0;
                    n_wi   = r_rlo;
                    n_wrs  = r_rlo_end - sz + 12'sd1;
                    n_wj   = r_clo;
                    n_wcs  = r_clo_end - sz + 12'sd1;
                end
            end
            S_UPD: begin
                if (upd_go) begin
                    if (win_last) begin
                        n_nres = 7'(r_nres + 7'd1);
                    end
                    if (j_end) begin
                        n_wi  = 10'(r_wi + 10'd1);
                        n_wrs = r_wrs + st;
                        n_wj  = r_clo;
                        n_wcs = r_clo_end - sz + 12'sd1;
                    end else begin
                        n_wj  = 10'(r_wj + 10'd1);
                        n_wcs = r_wcs + st;
                    end
                end
            end
            S_ADV: begin
                if (!last_col) begin
                    n_col = 9'(r_col + 9'd1);
                    if (r_clo_end == col_s) begin
                        n_clo     = 10'(r_clo + 10'd1);
                        n_clo_end = r_clo_end + st;
                    end
                    if (r_chinext == col_s + 12'sd1) begin
                        n_chi     = 10'(r_chi + 10'd1);
                        n_chinext = r_chinext + st;
                    end
                end else begin
                    n_col = 9'd0;
                    n_clo = {6'b0, r_lo0};  n_clo_end = r_lo0_end;
                    n_chi = {6'b0, r_hi0};  n_chinext = r_hinext0;
                    if (last_row) begin
                        n_row = 9'd0;
                        n_rlo = {6'b0, r_lo0};  n_rlo_end = r_lo0_end;
                        n_rhi = {6'b0, r_hi0};  n_rhinext = r_hinext0;
                        n_it  = 10'(r_rhi + 10'd1);
                        n_jt  = 10'(r_chi + 10'd1);
                        n_ei  = 10'd0;
                        n_ej  = 10'd0;
                    end else begin
                        n_row = 9'(r_row + 9'd1);
                        if (r_rlo_end == row_s) begin
                            n_rlo     = 10'(r_rlo + 10'd1);
                            n_rlo_end = r_rlo_end + st;
                        end
                        if (r_rhinext == row_s + 12'sd1) begin
                            n_rhi     = 10'(r_rhi + 10'd1);
                            n_rhinext = r_rhinext + st;
                        end
                    end
                end
            end
            S_EMPTY: begin
                if (e_done) begin
                    n_plane = 16'(r_plane + 16'd1);
                end else if (e_go) begin
                    if (e_hit) begin
                        n_nres = 7'(r_nres + 7'd1);
                    end
                    if (ej_nx >= r_ow) begin
                        n_ei = ei1;
                        n_ej = 10'd0;
                    end else begin
                        n_ej = ej_nx;
                    end
                end
            end
            default: ;
        endcase
    end

    // result path: one pending result so the last of a run can be flagged
    always_comb begin
        n_pend_v   = r_pend_v;
        n_pend     = r_pend;
        n_out      = r_out;
        n_out_last = r_out_last;
        n_out_v    = r_out_v && !i_out_ready;
        if (out_load) begin
            n_out      = r_pend;
            n_out_last = done_flush;
            n_out_v    = 1'b1;
        end
        if (emit_v) begin
            n_pend_v = 1'b1;
            n_pend   = emit_res;
        end else if (done_flush) begin
            n_pend_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (r_state == S_RD) begin
            r_rd <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_SETUP;
            r_in_width    <= 10'd1;
            r_in_height   <= 10'd1;
            r_window_size <= 4'd2;
            r_step        <= 4'd2;
            r_pad_total   <= 4'd1;
            r_plane       <= 16'd0;
            r_row         <= 9'd0;
            r_col         <= 9'd0;
            r_pend_v      <= 1'b0;
            r_out_v       <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_plane  <= n_plane;
            r_row    <= n_row;
            r_col    <= n_col;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IN_WIDTH:    r_in_width    <= i_cfg_data;
                    CFG_IN_HEIGHT:   r_in_height   <= i_cfg_data;
                    CFG_WINDOW_SIZE: r_window_size <= i_cfg_data[3:0];
                    CFG_STEP:        r_step        <= i_cfg_data[3:0];
                    CFG_PAD_TOTAL:   r_pad_total   <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_div_quo <= n_div_quo;  r_div_rem <= n_div_rem;  r_div_cnt <= n_div_cnt;
        r_ow <= n_ow;  r_oh <= n_oh;
        r_lo0 <= n_lo0;  r_hi0 <= n_hi0;  r_gj <= n_gj;
        r_lo0_end <= n_lo0_end;  r_hinext0 <= n_hinext0;  r_gstart <= n_gstart;
        r_rlo <= n_rlo;  r_rhi <= n_rhi;  r_clo <= n_clo;  r_chi <= n_chi;
        r_rlo_end <= n_rlo_end;  r_rhinext <= n_rhinext;
        r_clo_end <= n_clo_end;  r_chinext <= n_chinext;
        r_x <= n_x;
        r_wi <= n_wi;  r_wj <= n_wj;  r_wrs <= n_wrs;  r_wcs <= n_wcs;
        r_it <= n_it;  r_jt <= n_jt;  r_ei <= n_ei;  r_ej <= n_ej;
        r_nres <= n_nres;
        r_pend <= n_pend;
        r_out <= n_out;
        r_out_last <= n_out_last;
    end

    assign o_out_valid    = r_out_v;
    assign o_max_value    = r_out.max_value;
    assign o_src_row      = r_out.src_row;
    assign o_src_col      = r_out.src_col;
    assign o_window_empty = r_out.window_empty;
    assign o_out_row      = r_out.out_row;
    assign o_out_col      = r_out.out_col;
    assign o_plane        = r_out.plane;
    assign o_last_of_run  = r_out_last;

endmodule

// ===== hdl/mp2a_chk.sv =====
// Port-level checker for the max pooling block, bound to the top level
`timescale 1ns / 1ps
`include "max_pool_2d_argmax_assert.svh"
module mp2a_chk
    import mp2a_pkg::*;
(
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_we,
    input logic [2:0]                    i_cfg_idx,
    input logic [9:0]                    i_cfg_data,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic signed [SAMPLE_BITS-1:0] i_sample,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic signed [SAMPLE_BITS-1:0] o_max_value,
    input logic [8:0]                    o_src_row,
    input logic [8:0]                    o_src_col,
    input logic                          o_window_empty,
    input logic [9:0]                    o_out_row,
    input logic [9:0]                    o_out_col,
    input logic [15:0]                   o_plane,
    input logic                          o_last_of_run
);

    `MP2A_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    `MP2A_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_max_value) && $stable(o_out_row) && $stable(o_out_col) && $stable(o_last_of_run))
    // one sample at a time: busy right after a transfer
    `MP2A_NEXT(a_busy_after_in, i_in_valid && o_in_ready, !o_in_ready)
    `MP2A_IMPLIES(a_empty_fields, o_out_valid && o_window_empty, (o_max_value == MOST_NEG) && (o_src_row == 9'd0) && (o_src_col == 9'd0))

endmodule

bind max_pool_2d_argmax mp2a_chk u_mp2a_chk (.*);
